// ----- hdl/sorted_insert_priority_queue_unit_macros.svh -----
// Assertion macros shared by the queue RTL.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SIPQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SIPQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/sipq_pkg.sv -----
package sipq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int CAP_W     = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic               op;
		logic signed [31:0] value;
	} in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed_value;
		logic signed [31:0] head_value;
		logic               head_valid;
		logic [4:0]         occupancy;
	} out_t;

	typedef struct packed {
		logic               upd;
		logic               del;
		logic signed [31:0] value;
	} cell_cmd_t;

endpackage

// ----- hdl/sipq_cell.sv -----
module sipq_cell (
	input  logic                      clk,
	input  sipq_pkg::cell_cmd_t       cmd,
	input  logic                      valid,
	input  logic                      at_tail,
	input  logic                      prev_gt,
	input  logic signed [31:0]        prev_value,
	input  logic signed [31:0]        next_value,
	output logic                      gt,
	output logic signed [31:0]        value,
	output logic signed [31:0]        nxt
);
	import sipq_pkg::*;

	logic signed [31:0] value_q;

	assign gt    = valid && (cmd.value < value_q);
	assign value = value_q;

	always_comb begin
		nxt = value_q;
		if (cmd.del) begin
			nxt = next_value;
		end else if (prev_gt) begin
			nxt = prev_value;
		end else if (gt || at_tail) begin
			nxt = cmd.value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			value_q <= nxt;
		end
	end

endmodule

// ----- hdl/sorted_insert_priority_queue_unit.sv -----
// Min-first priority queue held as an ascending sorted row of DEPTH cells. Each request
// (enqueue or dequeue) is taken at one edge, which also loads its response into the
// output register, so the response is offered from the next cycle on; a new request is
// accepted every cycle unless a held response is stalled. Every cell compares the
// incoming value with its own entry in parallel and either holds, takes the new value,
// or takes a neighbor's entry, so an insert or a removal of the head finishes in a
// single shift of the row. Capacity may be written only while the queue is idle; values
// above DEPTH act as DEPTH.
`include "sorted_insert_priority_queue_unit_macros.svh"

module sorted_insert_priority_queue_unit #(
	parameter int DEPTH = sipq_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  sipq_pkg::in_t               in_req,
	output logic                        out_valid,
	input  logic                        out_stall,
	output sipq_pkg::out_t              out_rsp,
	input  logic                        cfg_we,
	input  logic [sipq_pkg::CAP_W-1:0]  cfg_wdata
);
	import sipq_pkg::*;

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_nxt;
	logic [CAP_W-1:0]   cap_q;
	logic               out_valid_q;
	out_t               out_q;

	logic               go;
	logic               del;
	logic               full;
	logic               empty;
	logic               reject;
	cell_cmd_t          cmd;

	logic               gt     [DEPTH];
	logic signed [31:0] values [DEPTH];
	logic signed [31:0] nxts   [DEPTH];

	assign in_stall = out_valid_q && out_stall;
	assign go       = in_valid && !in_stall;
	assign del      = (in_req.op == OP_DEQ);

	assign empty  = (count_q == '0);
	assign full   = (CMPW'(count_q) >= CMPW'(cap_q)) || (count_q == CW'(DEPTH));
	assign reject = del ? empty : full;

	assign cmd.upd   = go && !reject;
	assign cmd.del   = del;
	assign cmd.value = in_req.value;

	always_comb begin
		count_nxt = count_q;
		if (cmd.upd) begin
			count_nxt = del ? (count_q - 1'b1) : (count_q + 1'b1);
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic               prev_gt_w;
		logic signed [31:0] prev_w;
		logic signed [31:0] next_w;

		if (i == 0) begin : g_first
			assign prev_gt_w = 1'b0;
			assign prev_w    = in_req.value;
		end else begin : g_mid
			assign prev_gt_w = gt[i-1];
			assign prev_w    = values[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_w = values[i];
		end else begin : g_inner
			assign next_w = values[i+1];
		end

		sipq_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.valid      (CW'(i) < count_q),
			.at_tail    (CW'(i) == count_q),
			.prev_gt    (prev_gt_w),
			.prev_value (prev_w),
			.next_value (next_w),
			.gt         (gt[i]),
			.value      (values[i]),
			.nxt        (nxts[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (go) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_q.status        <= !reject ? ST_DONE : (del ? ST_EMPTY : ST_FULL);
			out_q.removed_value <= (del && !empty) ? values[0] : '0;
			out_q.head_value    <= (count_nxt == '0) ? '0 :
			                       (cmd.upd ? nxts[0] : values[0]);
			out_q.head_valid    <= (count_nxt != '0);
			out_q.occupancy     <= 5'(count_nxt);
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_q;

	`SIPQ_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "count above depth")
	`SIPQ_ASSERT_NXT(a_rsp_follows, go, out_valid, "request without response")
	`SIPQ_ASSERT_NXT(a_deq_empty, go && del && empty, out_rsp.status == ST_EMPTY && count_q == '0, "empty dequeue not rejected")
	`SIPQ_ASSERT_NXT(a_enq_grows, go && !del && !full, count_q == $past(count_q) + 1'b1, "enqueue did not advance count")
	`SIPQ_ASSERT_IMP(a_head_order, count_q >= CW'(2), values[0] <= values[1], "head out of order")

endmodule
